@@ design/spl_pkg.sv @@
package spl_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_IDLE   = 2'd0;
  localparam kind_t KIND_VERIFY = 2'd1;
  localparam kind_t KIND_CHECK  = 2'd2;
  localparam kind_t KIND_SET    = 2'd3;

  localparam logic [7:0] CH_VERIFY = 8'h26;  // '&'
  localparam logic [7:0] CH_CHECK  = 8'h2A;  // '*'
  localparam logic [7:0] CH_SET    = 8'h40;  // '@'
  localparam logic [7:0] CH_END    = 8'h24;  // '$'
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_T      = 8'h54;

  localparam int DEFAULT_LEN = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [3:0] FAIL_LIMIT_RESET = 4'd5;

  // one classified byte handed from front to back
  typedef struct packed {
    kind_t      kind;
    logic       last;
    logic [7:0] data;
  } spl_op_t;

  typedef struct packed {
    logic       alarm;
    logic       unlock;
    logic [7:0] reply;
  } spl_result_t;

  // factory default password
  function automatic logic [7:0] factory_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h4C;
      3'd1:    b = 8'h4A;
      3'd2:    b = 8'h31;
      3'd3:    b = 8'h39;
      3'd4:    b = 8'h39;
      3'd5:    b = 8'h33;
      3'd6:    b = 8'h24;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ design/serial_password_lock_controller_top.sv @@
// channel   | signals                            | payload
// ----------+------------------------------------+--------------------------------------
// rx in     | s_tvalid s_tready s_tdata[7:0]     | rx_byte
// reply out | m_tvalid m_tready m_tdata[15:0]    | reply_char, unlock_pulse, alarm_pulse
// config    | cfg_wen cfg_wdata[3:0]             | fail_limit
//
// the front takes one byte per cycle while the 4-entry queue has room
// an end-of-frame byte makes the back walk the frame: the compare
// or copy walks the frame buffer and password memory at one read port each per cycle
// after reset a load writes the default password, s_tready stays low meanwhile
// a reply waits in the output register; the back stalls on the next reply, the front on a full queue
module serial_password_lock_controller_top #(
  parameter int MAX_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] reply_char, [8] unlock_pulse, [9] alarm_pulse
  input  logic        cfg_wen,
  input  logic [3:0]  cfg_wdata
);
  import spl_pkg::*;

  logic        push;
  spl_op_t     push_op;
  logic        q_full;
  logic        q_not_empty;
  spl_op_t     q_head;
  logic        q_pop;
  logic        back_ready;
  spl_result_t result;

  spl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .q_full     (q_full),
    .back_ready (back_ready),
    .push       (push),
    .push_op    (push_op)
  );

  spl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  spl_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .op_valid  (q_not_empty),
    .op        (q_head),
    .op_pop    (q_pop),
    .ready     (back_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .result    (result)
  );

  assign m_tdata = {6'b0, result};

endmodule

@@ design/spl_front.sv @@
module spl_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,    // [7:0] rx_byte
  input  logic             q_full,
  input  logic             back_ready,
  output logic             push,
  output spl_pkg::spl_op_t push_op
);
  import spl_pkg::*;

  kind_t      frame_kind;
  logic       accept;
  logic [7:0] own_start;

  assign s_tready = !q_full && back_ready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    unique case (frame_kind)
      KIND_VERIFY: own_start = CH_VERIFY;
      KIND_CHECK:  own_start = CH_CHECK;
      KIND_SET:    own_start = CH_SET;
      default:     own_start = 8'h00;
    endcase
  end

  // inside a frame, zero bytes and the frame's own start character are dropped
  assign push = accept && (frame_kind != KIND_IDLE) && (s_tdata != 8'h00)
                && (s_tdata != own_start);

  assign push_op.kind = frame_kind;
  assign push_op.last = (s_tdata == CH_END);
  assign push_op.data = s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_kind <= KIND_IDLE;
    end else if (accept) begin
      if (frame_kind == KIND_IDLE) begin
        if (s_tdata == CH_VERIFY) begin
          frame_kind <= KIND_VERIFY;
        end else if (s_tdata == CH_CHECK) begin
          frame_kind <= KIND_CHECK;
        end else if (s_tdata == CH_SET) begin
          frame_kind <= KIND_SET;
        end
      end else if (push && push_op.last) begin
        frame_kind <= KIND_IDLE;
      end
    end
  end

endmodule

@@ design/spl_queue.sv @@
module spl_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  spl_pkg::spl_op_t push_op,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output spl_pkg::spl_op_t head
);
  import spl_pkg::*;

  spl_op_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/spl_back.sv @@
module spl_back #(
  parameter int MAX_LEN = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [3:0]           cfg_wdata,
  input  logic                 op_valid,
  input  spl_pkg::spl_op_t     op,
  output logic                 op_pop,
  output logic                 ready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output spl_pkg::spl_result_t result
);
  import spl_pkg::*;

  localparam int AW      = $clog2(MAX_LEN);
  localparam int IW      = $clog2(MAX_LEN + 1);
  localparam int DEF_LEN = (DEFAULT_LEN < MAX_LEN) ? DEFAULT_LEN : MAX_LEN;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  logic [2:0]    state;
  logic [2:0]    init_cnt;
  logic [3:0]    fail_limit;
  logic [3:0]    fail_count;
  kind_t         cur_kind;
  logic [IW-1:0] frame_index;
  logic          frame_overflow;
  logic [IW-1:0] password_length;
  logic [IW-1:0] walk;
  logic          pend;
  logic          copy;
  logic          mismatch;
  logic [AW-1:0] addr_q;

  logic [7:0]    fb_mem [MAX_LEN];
  logic [7:0]    pw_mem [MAX_LEN];
  logic [7:0]    fb_rd;
  logic [7:0]    pw_rd;

  logic          fb_we;
  logic          pw_we;
  logic [AW-1:0] pw_waddr;
  logic [7:0]    pw_wdata;
  logic [AW-1:0] rd_addr;
  logic          emit;
  logic          room;
  logic          fail_hit;
  logic [4:0]    cnt_inc;
  spl_result_t   res_next;

  assign ready   = (state != ST_INIT);
  assign op_pop  = (state == ST_IDLE) && op_valid;
  assign room    = (frame_index < IW'(MAX_LEN));
  assign fb_we   = op_pop && room;
  assign rd_addr = walk[AW-1:0];
  assign emit    = (state == ST_DRAIN) && (!m_tvalid || m_tready);

  // reset loads the factory password, then the walk copies frames on set
  assign pw_we    = (state == ST_INIT) || (pend && copy);
  assign pw_waddr = (state == ST_INIT) ? AW'(init_cnt) : addr_q;
  assign pw_wdata = (state == ST_INIT) ? factory_byte(init_cnt) : fb_rd;

  assign cnt_inc  = {1'b0, fail_count} + 5'd1;
  assign fail_hit = (cnt_inc >= {1'b0, fail_limit});

  always_comb begin
    res_next.unlock = 1'b0;
    res_next.alarm  = 1'b0;
    unique case (cur_kind)
      KIND_VERIFY: begin
        res_next.reply  = mismatch ? CH_F : CH_S;
        res_next.unlock = !mismatch;
        res_next.alarm  = mismatch && fail_hit;
      end
      KIND_CHECK: res_next.reply = mismatch ? CH_E : CH_C;
      default:    res_next.reply = frame_overflow ? CH_E : CH_T;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb_mem[frame_index[AW-1:0]] <= op.data;
    end
    if (pw_we) begin
      pw_mem[pw_waddr] <= pw_wdata;
    end
    fb_rd  <= fb_mem[rd_addr];
    pw_rd  <= pw_mem[rd_addr];
    addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_INIT;
      init_cnt        <= '0;
      fail_limit      <= FAIL_LIMIT_RESET;
      fail_count      <= '0;
      cur_kind        <= KIND_IDLE;
      frame_index     <= '0;
      frame_overflow  <= 1'b0;
      password_length <= IW'(DEF_LEN);
      walk            <= '0;
      pend            <= 1'b0;
      copy            <= 1'b0;
      mismatch        <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_wen) begin
        fail_limit <= cfg_wdata;
      end
      pend <= (state == ST_WALK) && (walk < frame_index);
      if (pend && !copy && (fb_rd != pw_rd)) begin
        mismatch <= 1'b1;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == 3'(DEF_LEN - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (op_valid) begin
            cur_kind <= op.kind;
            if (room) begin
              frame_index <= frame_index + 1'b1;
            end else begin
              frame_overflow <= 1'b1;
            end
            if (op.last) begin
              state <= ST_START;
            end
          end
        end
        ST_START: begin
          walk     <= '0;
          mismatch <= 1'b0;
          if (cur_kind == KIND_SET) begin
            copy  <= 1'b1;
            state <= frame_overflow ? ST_DRAIN : ST_WALK;
          end else begin
            copy <= 1'b0;
            if (frame_overflow || (frame_index != password_length)) begin
              mismatch <= 1'b1;
              state    <= ST_DRAIN;
            end else begin
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          // one entry read per cycle, compare or copy in the following cycle
          if (walk < frame_index) begin
            walk <= walk + 1'b1;
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (emit) begin
            if (cur_kind == KIND_SET && !frame_overflow) begin
              password_length <= frame_index;
            end
            if (cur_kind == KIND_VERIFY && mismatch) begin
              fail_count <= fail_hit ? 4'd0 : cnt_inc[3:0];
            end
            frame_index    <= '0;
            frame_overflow <= 1'b0;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    frame_index <= IW'(MAX_LEN))
    else $error("frame index beyond buffer");

  a_walk_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> !frame_overflow)
    else $error("walk started on an overflowed frame");

  a_unlock_reply: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.unlock) |-> (result.reply == CH_S && !result.alarm))
    else $error("unlock without success reply");

  a_alarm_reply: assert property (@(posedge clk) disable iff (rst)
    emit && res_next.alarm |=> (fail_count == 4'd0))
    else $error("alarm did not clear failure count");

endmodule
